// File: hw/rtl/ricdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ricdf_pkg: shared types and constants of the rational inverse-CDF sampler
// Table geometry, command codes, request/result structures and the control
// structure that drives the table memories.
// ----------------------------------------------------------------------------
package ricdf_pkg;

	localparam int POINTS      = 128;
	localparam int PT_W        = $clog2(POINTS);
	localparam int ENERGY_ROWS = 256;
	localparam int ROW_W       = $clog2(ENERGY_ROWS);
	localparam int MATERIALS   = 2;
	localparam int MAT_W       = $clog2(MATERIALS);
	localparam int ADDR_W      = MAT_W + ROW_W + PT_W;
	localparam int TBL_DEPTH   = 1 << ADDR_W;
	localparam int GUIDE_W     = 2 * PT_W;

	localparam int NORM_BITS = 22;
	localparam int ONE_Q12   = 4096;
	localparam int MUL_W     = 33;
	localparam int PROD_W    = 2 * MUL_W;

	typedef enum logic [1:0] {
		CMD_LOAD_POINT = 2'd0,
		CMD_LOAD_GUIDE = 2'd1,
		CMD_SAMPLE     = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [ROW_W-1:0]    energy_index;
		logic [PT_W-1:0]     point_index;
		logic [31:0]         cum_prob;
		logic [31:0]         mu_value;
		logic signed [31:0]  coef_a;
		logic signed [31:0]  coef_b;
		logic [GUIDE_W-1:0]  guide_bounds;
		logic [31:0]         grid_frac;
		logic [31:0]         rand_energy;
		logic [31:0]         rand_pointer;
		logic [31:0]         cutoff;
	} request_t;

	typedef struct packed {
		logic [31:0]     rmu;
		logic [PT_W-1:0] chosen_interval;
		logic            is_sample;
	} result_t;

	typedef struct packed {
		logic [31:0]        cum;
		logic [31:0]        mu;
		logic signed [31:0] coef_a;
		logic signed [31:0] coef_b;
	} point_t;

	typedef struct packed {
		logic              pt_we;
		logic              gd_we;
		logic              pt_re;
		logic              gd_re;
		logic [ADDR_W-1:0] addr;
	} tbl_req_t;

endpackage
`default_nettype wire

// File: hw/rtl/ricdf_tbl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ricdf_tbl: point and guide table memories
// One access per cycle to each memory, indexed by material, energy row and
// point; read data is registered.
// ----------------------------------------------------------------------------
module ricdf_tbl import ricdf_pkg::*; (
	input  wire logic               clk,
	input  wire tbl_req_t           ctrl,
	input  wire point_t             pt_wdata,
	input  wire logic [GUIDE_W-1:0] gd_wdata,
	output point_t                  pt_rdata_q,
	output logic [GUIDE_W-1:0]      gd_rdata_q
);

	point_t             point_mem [TBL_DEPTH];
	logic [GUIDE_W-1:0] guide_mem [TBL_DEPTH];

	always_ff @(posedge clk) begin
		if (ctrl.pt_we) begin
			point_mem[ctrl.addr] <= pt_wdata;
		end
		if (ctrl.pt_re) begin
			pt_rdata_q <= point_mem[ctrl.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.gd_we) begin
			guide_mem[ctrl.addr] <= gd_wdata;
		end
		if (ctrl.gd_re) begin
			gd_rdata_q <= guide_mem[ctrl.addr];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/ricdf_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ricdf_mul: shared signed multiplier
// Signed 33 x 33 multiply with a registered product, reused for every
// product of a sample.
// ----------------------------------------------------------------------------
module ricdf_mul import ricdf_pkg::*; (
	input  wire logic                     clk,
	input  wire logic signed [MUL_W-1:0]  op_a,
	input  wire logic signed [MUL_W-1:0]  op_b,
	output logic signed [PROD_W-1:0]      prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule
`default_nettype wire

// File: hw/rtl/ricdf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ricdf_div: iterative ratio unit
// Returns num/den as a Q1.32 fraction limited to [0, 1], one quotient bit
// per cycle by restoring division.
// ----------------------------------------------------------------------------
module ricdf_div import ricdf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] num,
	input  wire logic signed [63:0] den,
	output logic                    done_q,
	output logic [32:0]             quot_q
);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_PREP = 3'b010,
		D_RUN  = 3'b100
	} dstate_t;

	dstate_t     st_q;
	logic [4:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] dvs_q;
	logic [31:0] quo_q;
	logic        den_zero_q;
	logic [63:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q[62:0], 1'b0};
	assign fits   = rem_sh >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				D_IDLE: begin
					if (start) begin
						// Fold the sign of the denominator into the numerator.
						den_zero_q <= den == 64'sd0;
						rem_q      <= den[63] ? 64'(-num) : 64'(num);
						dvs_q      <= den[63] ? 64'(-den) : 64'(den);
						st_q       <= D_PREP;
					end
				end
				D_PREP: begin
					if (den_zero_q || rem_q[63] || rem_q == 64'd0) begin
						quot_q <= 33'd0;
						done_q <= 1'b1;
						st_q   <= D_IDLE;
					end else if (rem_q >= dvs_q) begin
						quot_q <= {1'b1, 32'd0};
						done_q <= 1'b1;
						st_q   <= D_IDLE;
					end else begin
						cnt_q <= '0;
						quo_q <= '0;
						st_q  <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= fits ? rem_sh - dvs_q : rem_sh;
					quo_q <= {quo_q[30:0], fits};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						quot_q <= {1'b0, quo_q[30:0], fits};
						done_q <= 1'b1;
						st_q   <= D_IDLE;
					end
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/rational_inverse_cdf_sampler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rational_inverse_cdf_sampler_unit: table-driven angular deflection sampler
// Loads fill point and guide tables; a sample maps its random pointer into
// [cutoff,1), binary-searches the interval and interpolates rationally.
//
//   port group            dir  handshake           payload
//   start/busy/request    in   start && !busy      request_t
//   done/result           out  done, one cycle     result_t
//   cfg_we/cfg_wdata      in   cfg_we              current material
//
// A load or an unused command is answered in the cycle after it is taken and
// leaves busy low. A sample keeps busy high, and its result appears in the
// first cycle that busy is low again. A sample computes ru, reads the guide,
// makes up to seven search probes, reads the two nodes, makes up to ten
// normalizing shifts and nine products on the shared multiplier and runs the
// iterative divider. An exact hit or a flat interval finishes right after the
// node reads.
// Reset clears the sequencer and the material register; table contents are
// undefined until loaded. The receiver cannot stall; each result is shown once.
// ----------------------------------------------------------------------------
module rational_inverse_cdf_sampler_unit import ricdf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire request_t request,
	output logic          done,
	output result_t       result,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata
);

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_RU    = 16'h0002,
		S_SLOT  = 16'h0004,
		S_GUIDE = 16'h0008,
		S_GWAIT = 16'h0010,
		S_SRCH  = 16'h0020,
		S_SCMP  = 16'h0040,
		S_RD0   = 16'h0080,
		S_RD1   = 16'h0100,
		S_CHK   = 16'h0200,
		S_NORM  = 16'h0400,
		S_MUL   = 16'h0800,
		S_DIVS  = 16'h1000,
		S_DIVW  = 16'h2000,
		S_INTP  = 16'h4000,
		S_FIN   = 16'h8000
	} state_t;

	localparam logic [PT_W-1:0] LO_MAX = PT_W'(POINTS - 2);

	state_t               state_q;
	logic [MAT_W-1:0]     mat_q;
	logic [ROW_W-1:0]     row_q;
	logic [31:0]          rp_q, cut_q, ru_q;
	logic [PT_W-1:0]      lo_q, hi_q, k_q;
	logic [31:0]          pp_q, xx_q, x1_q;
	logic signed [15:0]   a_q, b_q;
	logic [31:0]          d_q, r_q;
	logic [3:0]           op_q;
	logic [43:0]          dr_q, rr_q;
	logic signed [63:0]   num_q, den_q;
	logic [32:0]          t_q;
	logic [31:0]          span_q;
	logic                 up_q;
	logic                 done_q;
	result_t              result_q;

	logic                 accept;
	tbl_req_t             tbl_ctrl;
	point_t               pt_wdata, pt_rdata;
	logic [GUIDE_W-1:0]   gd_rdata;
	logic signed [MUL_W-1:0]  op_a, op_b;
	logic signed [PROD_W-1:0] prod;
	logic                 div_start, div_done;
	logic [32:0]          div_quot;

	logic [PT_W+31:0]     ru_scaled;
	logic [PT_W-1:0]      slot;
	logic                 search_go;
	logic [PT_W-1:0]      mid;
	logic signed [17:0]   s_w;
	logic                 up_w;
	logic [31:0]          span_w;
	logic [31:0]          delta;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// Guide slot is floor(ru * (POINTS-1) / 2^32).
	assign ru_scaled = {ru_q, PT_W'(0)} - (PT_W+32)'(ru_q);
	assign slot      = ru_scaled[PT_W+31:32];
	assign search_go = {1'b0, hi_q} > ({1'b0, lo_q} + (PT_W+1)'(1));
	assign mid       = PT_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign s_w       = 18'(ONE_Q12) + 18'(a_q) + 18'(b_q);
	assign up_w      = x1_q >= xx_q;
	assign span_w    = up_w ? x1_q - xx_q : xx_q - x1_q;
	assign delta     = t_q[32] ? span_q : prod[63:32];

	assign pt_wdata = '{cum: request.cum_prob, mu: request.mu_value,
		coef_a: request.coef_a, coef_b: request.coef_b};

	always_comb begin
		tbl_ctrl      = '0;
		tbl_ctrl.addr = {mat_q, row_q, lo_q};
		if (accept && request.cmd == CMD_LOAD_POINT) begin
			tbl_ctrl.pt_we = 1'b1;
			tbl_ctrl.addr  = {mat_q, request.energy_index, request.point_index};
		end else if (accept && request.cmd == CMD_LOAD_GUIDE) begin
			tbl_ctrl.gd_we = 1'b1;
			tbl_ctrl.addr  = {mat_q, request.energy_index, request.point_index};
		end else if (state_q == S_GUIDE) begin
			tbl_ctrl.gd_re = 1'b1;
			tbl_ctrl.addr  = {mat_q, row_q, slot};
		end else if (state_q == S_SRCH && search_go) begin
			tbl_ctrl.pt_re = 1'b1;
			tbl_ctrl.addr  = {mat_q, row_q, mid};
		end else if (state_q == S_RD0) begin
			tbl_ctrl.pt_re = 1'b1;
		end else if (state_q == S_RD1) begin
			tbl_ctrl.pt_re = 1'b1;
			tbl_ctrl.addr  = {mat_q, row_q, lo_q + PT_W'(1)};
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (state_q == S_RU) begin
			op_a = $signed({1'b0, rp_q});
			op_b = $signed({1'b0, 32'(-cut_q)});
		end else if (state_q == S_INTP) begin
			op_a = $signed({1'b0, t_q[31:0]});
			op_b = $signed({1'b0, span_w});
		end else if (state_q == S_MUL) begin
			case (op_q)
				4'd0: begin op_a = $signed({1'b0, d_q}); op_b = $signed({1'b0, r_q}); end
				4'd1: begin op_a = $signed({1'b0, d_q}); op_b = $signed({1'b0, d_q}); end
				4'd2: begin op_a = $signed({1'b0, r_q}); op_b = $signed({1'b0, r_q}); end
				4'd3: begin op_a = MUL_W'(s_w); op_b = $signed({11'd0, dr_q[21:0]}); end
				4'd4: begin op_a = MUL_W'(s_w); op_b = $signed({11'd0, dr_q[43:22]}); end
				4'd5: begin op_a = MUL_W'(a_q); op_b = $signed({11'd0, dr_q[21:0]}); end
				4'd6: begin op_a = MUL_W'(a_q); op_b = $signed({11'd0, dr_q[43:22]}); end
				4'd7: begin op_a = MUL_W'(b_q); op_b = $signed({11'd0, rr_q[21:0]}); end
				4'd8: begin op_a = MUL_W'(b_q); op_b = $signed({11'd0, rr_q[43:22]}); end
				default: begin op_a = '0; op_b = '0; end
			endcase
		end
	end

	assign div_start = state_q == S_DIVS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
		end else if (cfg_we) begin
			mat_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			op_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (request.cmd)
							CMD_SAMPLE: begin
								// Row ke+1 is taken with probability grid_frac unless ke is the last row.
								if (request.rand_energy < request.grid_frac &&
									request.energy_index != ROW_W'(ENERGY_ROWS - 1)) begin
									row_q <= request.energy_index + ROW_W'(1);
								end else begin
									row_q <= request.energy_index;
								end
								rp_q    <= request.rand_pointer;
								cut_q   <= request.cutoff;
								state_q <= S_RU;
							end
							default: begin
								done_q   <= 1'b1;
								result_q <= '0;
							end
						endcase
					end
				end
				S_RU: state_q <= S_SLOT;
				S_SLOT: begin
					ru_q    <= (cut_q == 32'd0) ? rp_q : cut_q + prod[63:32];
					state_q <= S_GUIDE;
				end
				S_GUIDE: state_q <= S_GWAIT;
				S_GWAIT: begin
					lo_q    <= gd_rdata[PT_W-1:0];
					hi_q    <= gd_rdata[GUIDE_W-1:PT_W];
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (search_go) begin
						k_q     <= mid;
						state_q <= S_SCMP;
					end else begin
						lo_q    <= (lo_q > LO_MAX) ? LO_MAX : lo_q;
						state_q <= S_RD0;
					end
				end
				S_SCMP: begin
					if (ru_q > pt_rdata.cum) begin
						lo_q <= k_q;
					end else begin
						hi_q <= k_q;
					end
					state_q <= S_SRCH;
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: begin
					pp_q    <= pt_rdata.cum;
					xx_q    <= pt_rdata.mu;
					a_q     <= pt_rdata.coef_a[31:16];
					b_q     <= pt_rdata.coef_b[31:16];
					state_q <= S_CHK;
				end
				S_CHK: begin
					x1_q <= pt_rdata.mu;
					// An exact hit or a flat interval answers the lower node.
					if (ru_q <= pp_q || pt_rdata.cum <= pp_q) begin
						done_q   <= 1'b1;
						result_q <= '{rmu: xx_q, chosen_interval: lo_q, is_sample: 1'b1};
						state_q  <= S_IDLE;
					end else begin
						d_q     <= pt_rdata.cum - pp_q;
						r_q     <= ru_q - pp_q;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (|((d_q | r_q) >> NORM_BITS)) begin
						d_q <= d_q >> 1;
						r_q <= r_q >> 1;
					end else begin
						op_q    <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					// The product register holds the result of the previous step.
					op_q <= op_q + 4'd1;
					case (op_q)
						4'd1: dr_q  <= prod[43:0];
						4'd2: den_q <= $signed({prod[51:0], 12'd0});
						4'd3: rr_q  <= prod[43:0];
						4'd4: num_q <= prod[63:0];
						4'd5: num_q <= num_q + $signed({prod[41:0], 22'd0});
						4'd6: den_q <= den_q + prod[63:0];
						4'd7: den_q <= den_q + $signed({prod[41:0], 22'd0});
						4'd8: den_q <= den_q + prod[63:0];
						4'd9: begin
							den_q   <= den_q + $signed({prod[41:0], 22'd0});
							state_q <= S_DIVS;
						end
						default: ;
					endcase
				end
				S_DIVS: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_done) begin
						t_q     <= div_quot;
						state_q <= S_INTP;
					end
				end
				S_INTP: begin
					up_q    <= up_w;
					span_q  <= span_w;
					state_q <= S_FIN;
				end
				S_FIN: begin
					done_q          <= 1'b1;
					result_q.rmu    <= up_q ? xx_q + delta : xx_q - delta;
					result_q.chosen_interval <= lo_q;
					result_q.is_sample <= 1'b1;
					state_q         <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ricdf_tbl u_tbl (
		.clk        (clk),
		.ctrl       (tbl_ctrl),
		.pt_wdata   (pt_wdata),
		.gd_wdata   (request.guide_bounds),
		.pt_rdata_q (pt_rdata),
		.gd_rdata_q (gd_rdata)
	);

	ricdf_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod)
	);

	ricdf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done_q (div_done),
		.quot_q (div_quot)
	);

	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.is_sample |-> result.rmu == 32'd0 && result.chosen_interval == '0)
		else $error("load acknowledge carries nonzero payload");

	a_mid_inside: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCMP |-> k_q > lo_q && k_q < hi_q)
		else $error("search probe outside its bounds");

	a_interval_max: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.is_sample |-> result.chosen_interval <= LO_MAX)
		else $error("chosen interval has no upper node");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIVW)
		else $error("divider finished outside its wait state");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result without a request");

endmodule
`default_nettype wire
